@@ hdl/rfps_pkg.sv @@
// Shared types and constants of the random frame plane selector.
package rfps_pkg;

    // Generator word and serial step counter
    localparam int RNG_W = 32;
    localparam int CNT_W = $clog2(RNG_W);
    localparam logic [RNG_W-1:0] LCG_MUL = 32'd1103515245;
    localparam logic [RNG_W-1:0] LCG_ADD = 32'd12345;

    // Result field width
    localparam int OUT_W = 5;

    // Walk run draws
    localparam int STRIDE_SPAN = 5;
    localparam int RUN_SPAN = 6;
    localparam int RUN_MIN = 2;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WALK_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEED = 1'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LCG,
        S_MOD,
        S_OUT
    } rfps_state_t;

    typedef enum logic [1:0] {
        P_SHOW,
        P_STRIDE,
        P_RUN,
        P_WALK
    } rfps_phase_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rfps_unit_sts_t;

endpackage

@@ hdl/rfps_if.sv @@
// Stream channel interfaces for frame events and slot results.
interface rfps_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface rfps_out_if;
    logic                       valid;
    logic                       ready;
    logic [rfps_pkg::OUT_W-1:0] write_slot;
    logic [rfps_pkg::OUT_W-1:0] show_slot;

    modport source (output valid, output write_slot, output show_slot, input ready);
    modport sink (input valid, input write_slot, input show_slot, output ready);
endinterface

@@ hdl/rfps_lcg.sv @@
// Bit-serial linear congruential generator step: y = x * MUL + ADD mod 2^32.
module rfps_lcg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rfps_pkg::RNG_W-1:0] x,
    output logic [rfps_pkg::RNG_W-1:0] y,
    output rfps_pkg::rfps_unit_sts_t   sts
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [rfps_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [rfps_pkg::RNG_W-1:0]        xs_reg, xs_next;
    logic [rfps_pkg::RNG_W-1:0]        ms_reg, ms_next;
    logic [rfps_pkg::RNG_W-1:0]        acc_reg, acc_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        xs_next   = xs_reg;
        ms_next   = ms_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            xs_next   = x;
            ms_next   = rfps_pkg::LCG_MUL;
            acc_next  = rfps_pkg::LCG_ADD;
        end
        else if (busy_reg)
        begin
            // add the shifted multiplier for each set bit of x, low bit first
            acc_next = acc_reg + (xs_reg[0] ? ms_reg : '0);
            xs_next  = xs_reg >> 1;
            ms_next  = ms_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rfps_pkg::CNT_W'(rfps_pkg::RNG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xs_reg  <= xs_next;
        ms_reg  <= ms_next;
        acc_reg <= acc_next;
    end

    assign y        = acc_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

@@ hdl/rfps_mod.sv @@
// Bit-serial restoring remainder of a 32-bit dividend by a narrow divisor.
module rfps_mod
#(
    parameter int MOD_W = 6
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rfps_pkg::RNG_W-1:0] dividend,
    input  logic [MOD_W-1:0]           divisor,
    output logic [MOD_W-1:0]           remainder,
    output rfps_pkg::rfps_unit_sts_t   sts
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [rfps_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [rfps_pkg::RNG_W-1:0]        dvd_reg, dvd_next;
    logic [MOD_W-1:0]                  dvs_reg, dvs_next;
    logic [MOD_W-1:0]                  rem_reg, rem_next;
    logic [MOD_W:0]                    trial;

    assign trial = {rem_reg, dvd_reg[rfps_pkg::RNG_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // bring in the next dividend bit, high bit first
            if (trial >= {1'b0, dvs_reg})
                rem_next = MOD_W'(trial - {1'b0, dvs_reg});
            else
                rem_next = trial[MOD_W-1:0];
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rfps_pkg::CNT_W'(rfps_pkg::RNG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign remainder = rem_reg;
    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;

endmodule

@@ hdl/random_frame_plane_selector.sv @@
// Sequence: a random-mode frame runs one serial draw and one serial remainder, a walk step
//   one serial remainder, a walk run start a draw and a remainder each for shown slot, stride and run.
// Throughput: one frame event at a time; the next is taken as soon as the result has moved
//   into the output register, which the serial multiplier and remainder unit pace.
// Reset: rst_n clears slot pointer, fill count, run timer, stride, shown slot and the
//   registers; the generator starts from the seed value 0.
module random_frame_plane_selector
#(
    parameter int SLOT_COUNT = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    rfps_in_if.sink                       in_ch,
    rfps_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rfps_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int FILL_W = $clog2(SLOT_COUNT + 1);
    localparam int MOD_W  = (FILL_W > 3) ? FILL_W : 3;
    localparam int T_W    = FILL_W + 3;

    // Sequencer
    rfps_pkg::rfps_state_t             state_reg, state_next;
    rfps_pkg::rfps_phase_t             phase_reg, phase_next;

    // Frame ring state
    logic [SLOT_W-1:0]                 next_slot_reg, next_slot_next;
    logic [FILL_W-1:0]                 fill_reg, fill_next;
    logic [2:0]                        run_timer_reg, run_timer_next;
    logic signed [2:0]                 stride_reg, stride_next;
    logic [SLOT_W-1:0]                 show_reg, show_next;
    logic [SLOT_W-1:0]                 written_reg, written_next;
    logic [rfps_pkg::RNG_W-1:0]        rng_reg, rng_next;

    // Registers
    logic                              walk_mode_reg, walk_mode_next;
    logic [rfps_pkg::RNG_W-1:0]        seed_reg, seed_next;

    // Output register
    logic                              out_valid_reg, out_valid_next;
    logic [rfps_pkg::OUT_W-1:0]        out_write_reg, out_write_next;
    logic [rfps_pkg::OUT_W-1:0]        out_show_reg, out_show_next;

    // Serial units
    logic                              lcg_start;
    logic [rfps_pkg::RNG_W-1:0]        lcg_y;
    rfps_pkg::rfps_unit_sts_t          lcg_sts;
    logic                              mod_start;
    logic [rfps_pkg::RNG_W-1:0]        mod_dividend;
    logic [MOD_W-1:0]                  mod_divisor;
    logic [MOD_W-1:0]                  mod_rem;
    rfps_pkg::rfps_unit_sts_t          mod_sts;

    // Frame event with restart applied
    logic [SLOT_W-1:0]                 slot_eff;
    logic [FILL_W-1:0]                 fill_eff;
    logic [FILL_W-1:0]                 fill_inc;
    logic [2:0]                        timer_eff;
    logic [SLOT_W-1:0]                 show_eff;
    logic [SLOT_W-1:0]                 slot_wrap;
    logic [T_W-1:0]                    walk_sum;

    // Masked result fields
    logic [SLOT_W+rfps_pkg::OUT_W-1:0] written_wide;
    logic [SLOT_W+rfps_pkg::OUT_W-1:0] show_wide;

    logic                              cfg_wr;
    logic [rfps_pkg::CFG_IDX_W-1:0]    cfg_idx;

    rfps_lcg u_lcg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lcg_start),
        .x     (rng_reg),
        .y     (lcg_y),
        .sts   (lcg_sts)
    );

    rfps_mod #(.MOD_W(MOD_W)) u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (mod_divisor),
        .remainder (mod_rem),
        .sts       (mod_sts)
    );

    // APB register access; pready is tied high, so a write lands on the access cycle
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[rfps_pkg::ADDR_W-1:2];

    always_comb
    begin
        case (cfg_idx)
            rfps_pkg::CFG_WALK_MODE: prdata = {31'd0, walk_mode_reg};
            rfps_pkg::CFG_RNG_SEED:  prdata = seed_reg;
            default:                 prdata = '0;
        endcase
    end

    // Restart clears the ring counters before the frame is handled
    assign slot_eff  = in_ch.restart ? '0 : next_slot_reg;
    assign fill_eff  = in_ch.restart ? '0 : fill_reg;
    assign timer_eff = in_ch.restart ? '0 : run_timer_reg;
    assign show_eff  = in_ch.restart ? '0 : show_reg;
    assign fill_inc  = (fill_eff < FILL_W'(SLOT_COUNT)) ? fill_eff + 1'b1 : fill_eff;
    assign slot_wrap = (slot_eff == SLOT_W'(SLOT_COUNT - 1)) ? '0 : slot_eff + 1'b1;

    // Walk step: bias by four fill counts so a negative stride stays positive
    assign walk_sum = T_W'(show_eff) + T_W'({fill_inc, 2'b00})
                    + {{(T_W-3){stride_reg[2]}}, stride_reg};

    assign written_wide = {{rfps_pkg::OUT_W{1'b0}}, written_reg};
    assign show_wide    = {{rfps_pkg::OUT_W{1'b0}}, show_reg};

    assign in_ch.ready       = (state_reg == rfps_pkg::S_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.write_slot = out_write_reg;
    assign out_ch.show_slot  = out_show_reg;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        next_slot_next = next_slot_reg;
        fill_next      = fill_reg;
        run_timer_next = run_timer_reg;
        stride_next    = stride_reg;
        show_next      = show_reg;
        written_next   = written_reg;
        rng_next       = rng_reg;
        walk_mode_next = walk_mode_reg;
        seed_next      = seed_reg;
        out_valid_next = out_valid_reg;
        out_write_next = out_write_reg;
        out_show_next  = out_show_reg;
        lcg_start      = 1'b0;
        mod_start      = 1'b0;
        mod_dividend   = '0;
        mod_divisor    = '0;

        // A seed write also reloads the generator
        if (cfg_wr)
        begin
            case (cfg_idx)
                rfps_pkg::CFG_WALK_MODE: walk_mode_next = pwdata[0];
                rfps_pkg::CFG_RNG_SEED:
                begin
                    seed_next = pwdata;
                    rng_next  = pwdata;
                end
                default: ;
            endcase
        end

        if (out_ch.valid && out_ch.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            rfps_pkg::S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    written_next   = slot_eff;
                    next_slot_next = slot_wrap;
                    fill_next      = fill_inc;
                    run_timer_next = timer_eff;
                    show_next      = show_eff;
                    if (walk_mode_reg && (timer_eff != 3'd0))
                    begin
                        // continue the run: one remainder, no draw
                        mod_start    = 1'b1;
                        mod_dividend = rfps_pkg::RNG_W'(walk_sum);
                        mod_divisor  = MOD_W'(fill_inc);
                        phase_next   = rfps_pkg::P_WALK;
                        state_next   = rfps_pkg::S_MOD;
                    end
                    else
                    begin
                        lcg_start  = 1'b1;
                        phase_next = rfps_pkg::P_SHOW;
                        state_next = rfps_pkg::S_LCG;
                    end
                end
            end

            rfps_pkg::S_LCG:
            begin
                if (lcg_sts.done)
                begin
                    rng_next     = lcg_y;
                    mod_start    = 1'b1;
                    mod_dividend = lcg_y;
                    case (phase_reg)
                        rfps_pkg::P_STRIDE: mod_divisor = MOD_W'(rfps_pkg::STRIDE_SPAN);
                        rfps_pkg::P_RUN:    mod_divisor = MOD_W'(rfps_pkg::RUN_SPAN);
                        default:            mod_divisor = MOD_W'(fill_reg);
                    endcase
                    state_next = rfps_pkg::S_MOD;
                end
            end

            rfps_pkg::S_MOD:
            begin
                if (mod_sts.done)
                begin
                    case (phase_reg)
                        rfps_pkg::P_WALK:
                        begin
                            show_next      = mod_rem[SLOT_W-1:0];
                            run_timer_next = run_timer_reg - 3'd1;
                            state_next     = rfps_pkg::S_OUT;
                        end
                        rfps_pkg::P_SHOW:
                        begin
                            show_next = mod_rem[SLOT_W-1:0];
                            if (walk_mode_reg)
                            begin
                                lcg_start  = 1'b1;
                                phase_next = rfps_pkg::P_STRIDE;
                                state_next = rfps_pkg::S_LCG;
                            end
                            else
                                state_next = rfps_pkg::S_OUT;
                        end
                        rfps_pkg::P_STRIDE:
                        begin
                            // remainders 0..4 map to strides -2, -1, 1, 2, 3
                            if (mod_rem[2:0] < 3'd2)
                                stride_next = mod_rem[2:0] - 3'd2;
                            else
                                stride_next = mod_rem[2:0] - 3'd1;
                            lcg_start  = 1'b1;
                            phase_next = rfps_pkg::P_RUN;
                            state_next = rfps_pkg::S_LCG;
                        end
                        default:
                        begin
                            run_timer_next = mod_rem[2:0] + 3'(rfps_pkg::RUN_MIN);
                            state_next     = rfps_pkg::S_OUT;
                        end
                    endcase
                end
            end

            rfps_pkg::S_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_write_next = written_wide[rfps_pkg::OUT_W-1:0];
                    out_show_next  = show_wide[rfps_pkg::OUT_W-1:0];
                    state_next     = rfps_pkg::S_IDLE;
                end
            end

            default: state_next = rfps_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rfps_pkg::S_IDLE;
            phase_reg     <= rfps_pkg::P_SHOW;
            next_slot_reg <= '0;
            fill_reg      <= '0;
            run_timer_reg <= '0;
            stride_reg    <= '0;
            show_reg      <= '0;
            rng_reg       <= '0;
            walk_mode_reg <= 1'b0;
            seed_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            next_slot_reg <= next_slot_next;
            fill_reg      <= fill_next;
            run_timer_reg <= run_timer_next;
            stride_reg    <= stride_next;
            show_reg      <= show_next;
            rng_reg       <= rng_next;
            walk_mode_reg <= walk_mode_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        written_reg   <= written_next;
        out_write_reg <= out_write_next;
        out_show_reg  <= out_show_next;
    end

    // The serial units are quiet whenever a new frame event can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> (!lcg_sts.busy && !mod_sts.busy))
        else $error("serial unit busy while idle");

    // A generator result only arrives while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        lcg_sts.done |-> (state_reg == rfps_pkg::S_LCG))
        else $error("generator done outside draw state");

    // A walk step never runs with an expired run timer
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rfps_pkg::S_MOD && phase_reg == rfps_pkg::P_WALK)
            |-> (run_timer_reg != 3'd0))
        else $error("walk step with zero run timer");

    // Any delivered result implies at least one filled slot
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (fill_reg != '0))
        else $error("result with empty ring");

    // Between frames the shown slot is always a filled one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rfps_pkg::S_IDLE && fill_reg != '0)
            |-> (FILL_W'(show_reg) < fill_reg))
        else $error("shown slot beyond fill count");

endmodule

@@ bench/rfps_checker.sv @@
`timescale 1ns / 1ps
// Checker that predicts write and show slots from observed transactions and compares them.
module rfps_checker
#(
    parameter int SLOT_COUNT = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    rfps_in_if                          in_ch,
    rfps_out_if                         out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rfps_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    output int                          fault_count,
    output int                          outstanding
);

    typedef struct packed {
        logic [rfps_pkg::OUT_W-1:0] write_slot;
        logic [rfps_pkg::OUT_W-1:0] show_slot;
    } slot_pair_t;

    // Shadow copy of the block's registers and frame state
    logic                       walk_mode;
    logic [rfps_pkg::RNG_W-1:0] rng_state;
    logic [rfps_pkg::OUT_W-1:0] slot_ptr;
    logic [5:0]                 filled;
    logic [2:0]                 run_left;
    int                         stride;
    logic [rfps_pkg::OUT_W-1:0] shown;
    int                         faults;

    slot_pair_t pending_slots[$];

    function automatic logic [rfps_pkg::RNG_W-1:0] roll();
        rng_state = rng_state * rfps_pkg::LCG_MUL + rfps_pkg::LCG_ADD;
        return rng_state;
    endfunction

    function automatic slot_pair_t take_frame(input logic restart);
        slot_pair_t res;
        int         span;
        int         step;
        if (restart)
        begin
            slot_ptr = '0;
            filled   = '0;
            run_left = '0;
            shown    = '0;
        end
        res.write_slot = slot_ptr;
        if (filled < SLOT_COUNT)
            filled = filled + 1'b1;
        span = int'(filled);
        if (walk_mode && run_left != 0)
        begin
            // continue the run, wrapping into the filled range
            shown    = rfps_pkg::OUT_W'((int'(shown) + stride + 4 * span) % span);
            run_left = run_left - 1'b1;
        end
        else
        begin
            shown = rfps_pkg::OUT_W'(roll() % 32'(span));
            if (walk_mode)
            begin
                step = int'(roll() % 32'(rfps_pkg::STRIDE_SPAN)) - 2;
                if (step >= 0)
                    step++;
                stride   = step;
                run_left = 3'(roll() % 32'(rfps_pkg::RUN_SPAN) + 32'(rfps_pkg::RUN_MIN));
            end
        end
        slot_ptr = (int'(slot_ptr) + 1 >= SLOT_COUNT) ? '0 : slot_ptr + 1'b1;
        res.show_slot = shown;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        slot_pair_t                     got;
        slot_pair_t                     want;
        logic [rfps_pkg::CFG_IDX_W-1:0] reg_idx;
        if (!rst_n)
        begin
            walk_mode = 1'b0;
            rng_state = '0;
            slot_ptr  = '0;
            filled    = '0;
            run_left  = '0;
            stride    = 0;
            shown     = '0;
            faults    = 0;
            pending_slots.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                reg_idx = paddr[rfps_pkg::ADDR_W-1:2];
                if (reg_idx == rfps_pkg::CFG_WALK_MODE)
                    walk_mode = pwdata[0];
                else if (reg_idx == rfps_pkg::CFG_RNG_SEED)
                    rng_state = pwdata;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got.write_slot = out_ch.write_slot;
                got.show_slot  = out_ch.show_slot;
                if (pending_slots.size() == 0)
                begin
                    $error("unexpected result: write_slot %0d show_slot %0d",
                           got.write_slot, got.show_slot);
                    faults++;
                end
                else
                begin
                    want = pending_slots.pop_front();
                    if (got.write_slot !== want.write_slot)
                    begin
                        $error("write_slot: expected %0d, actual %0d",
                               want.write_slot, got.write_slot);
                        faults++;
                    end
                    if (got.show_slot !== want.show_slot)
                    begin
                        $error("show_slot: expected %0d, actual %0d",
                               want.show_slot, got.show_slot);
                        faults++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                pending_slots.push_back(take_frame(in_ch.restart));
        end
        fault_count <= faults;
        outstanding <= pending_slots.size();
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top: frame event stimulus, config writes, result back-pressure and verdict.
module tb_top;

    localparam int SLOT_COUNT   = 32;
    localparam int FRAME_GOAL   = 1200;
    // Covers a walk run start plus the longest receiver stall and sender gap
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n;

    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [rfps_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    int fault_count;
    int outstanding;

    rfps_in_if  in_ch();
    rfps_out_if out_ch();

    always #1 clk = ~clk;

    random_frame_plane_selector #(
        .SLOT_COUNT (SLOT_COUNT)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rfps_checker #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .fault_count (fault_count),
        .outstanding (outstanding)
    );

    // ------------------------------------------------------------------
    // Watchdog: count cycles in which no transaction moves on either channel
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern chosen per phase by the stimulus process
    //   0 = always ready, 1 = light random stalls, 2 = heavy random stalls,
    //   3 = long alternating windows of ready and stall
    // ------------------------------------------------------------------
    logic [1:0]  stall_sel = 2'd0;
    logic [15:0] stall_lfsr;
    logic [5:0]  stall_window = '0;

    always @(posedge clk)
    begin
        stall_lfsr   <= {stall_lfsr[14:0], stall_lfsr[15] ^ stall_lfsr[13]
                         ^ stall_lfsr[12] ^ stall_lfsr[10]};
        stall_window <= stall_window + 1'b1;
        case (stall_sel)
            2'd0:    out_ch.ready <= 1'b1;
            2'd1:    out_ch.ready <= (stall_lfsr[1:0] != 2'b00);
            2'd2:    out_ch.ready <= stall_lfsr[0];
            default: out_ch.ready <= stall_window[5];
        endcase
    end

    // ------------------------------------------------------------------
    // Sender pacing state
    // ------------------------------------------------------------------
    bit steady;
    int gap_max;
    int burst_left;

    // Offer one frame event and hold it until the block takes it, then
    // drop valid for a random gap when the current burst runs out.
    task automatic send_frame(input logic restart);
        in_ch.valid   <= 1'b1;
        in_ch.restart <= restart;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (!steady)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
        end
    endtask

    // Drop valid and hold until every predicted result has been taken.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Setup and access phase, then the bus returns to idle.
    task automatic write_reg(input logic [rfps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= rfps_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int random_frames;
        int phase_len;
        int restart_odds;

        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.restart = 1'b0;
        out_ch.ready  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        stall_lfsr    = 16'($urandom_range(1, 16'hFFFF));
        steady        = 1'b1;
        gap_max       = 3;
        burst_left    = 1;
        random_frames = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Random mode from the zero seed, a restart in the middle
        write_reg(rfps_pkg::CFG_WALK_MODE, 32'd0);
        write_reg(rfps_pkg::CFG_RNG_SEED, 32'd0);
        send_frame(1'b0);
        send_frame(1'b0);
        send_frame(1'b1);
        send_frame(1'b0);

        // Walk mode from an all-ones seed; restart leaves the stride alone,
        // and the frame after it is mid-run so the run stays pending
        drain();
        write_reg(rfps_pkg::CFG_WALK_MODE, 32'd1);
        write_reg(rfps_pkg::CFG_RNG_SEED, 32'hFFFF_FFFF);
        send_frame(1'b1);
        send_frame(1'b0);
        send_frame(1'b0);
        send_frame(1'b1);
        send_frame(1'b0);

        // Leave walk mode with a run pending, then come back to resume it
        drain();
        write_reg(rfps_pkg::CFG_WALK_MODE, 32'd0);
        send_frame(1'b0);
        send_frame(1'b0);
        drain();
        write_reg(rfps_pkg::CFG_WALK_MODE, 32'd1);
        send_frame(1'b0);
        send_frame(1'b0);
        send_frame(1'b0);

        // Seed with the top bit set in walk mode
        drain();
        write_reg(rfps_pkg::CFG_RNG_SEED, 32'h8000_0001);
        send_frame(1'b0);
        send_frame(1'b0);

        // Random phases: mostly long fills that saturate the ring, some with
        // frequent restarts so strides exceed a small fill count
        while (random_frames < FRAME_GOAL)
        begin
            drain();
            if ($urandom_range(0, 1))
                write_reg(rfps_pkg::CFG_WALK_MODE, 32'($urandom_range(0, 1)));
            case ($urandom_range(0, 5))
                0:       write_reg(rfps_pkg::CFG_RNG_SEED, 32'd0);
                1:       write_reg(rfps_pkg::CFG_RNG_SEED, 32'hFFFF_FFFF);
                2, 3:    write_reg(rfps_pkg::CFG_RNG_SEED, $urandom);
                default: ;
            endcase
            stall_sel    <= 2'($urandom_range(0, 3));
            steady        = ($urandom_range(0, 3) == 0);
            gap_max       = $urandom_range(0, 1) ? 3 : 30;
            burst_left    = $urandom_range(1, 16);
            phase_len     = $urandom_range(10, 120);
            restart_odds  = ($urandom_range(0, 2) == 0) ? 6 : 60;
            repeat (phase_len)
                send_frame($urandom_range(0, restart_odds - 1) == 0);
            random_frames += phase_len;
        end

        // Hold off until the last results are in, then let the block settle
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
hdl/rfps_pkg.sv
hdl/rfps_if.sv
hdl/rfps_lcg.sv
hdl/rfps_mod.sv
hdl/random_frame_plane_selector.sv
bench/rfps_checker.sv
bench/tb_top.sv
